// ===== design/bucketed_hash_map_top_macros.svh =====
// Assertion macros for the bucketed hash map.
// Used by bucketed_hash_map_top only.
`ifndef BUCKETED_HASH_MAP_TOP_MACROS_SVH
`define BUCKETED_HASH_MAP_TOP_MACROS_SVH
// implication checked every clock outside reset
`define BHM_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define BHM_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== design/bhm_pkg.sv =====
// Types and codes shared by the bucketed hash map modules.
// No dependencies.
package bhm_pkg;
	typedef enum logic [1:0] {
		OP_PUT = 2'd0, OP_GET = 2'd1, OP_REMOVE = 2'd2, OP_GET_OR_INSERT = 2'd3
	} op_t;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_READ, S_SCAN, S_WRITE, S_OUT, S_CLEAR
	} state_t;
endpackage

// ===== design/bhm_ram.sv =====
// Generic single-port-write, one-read synchronous RAM, registered read.
// No dependencies.
module bhm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== design/bhm_divider.sv =====
// Iterative restoring modulo: 32-bit key mod a divisor, one bit per cycle.
// Depends on nothing.
module bhm_divider #(
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] remainder
);
	logic [31:0]   quo_q;
	logic [DW:0]   rem_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	assign trial = {rem_q[DW-1:0], quo_q[31]} - {1'b0, divisor};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// done follows the last step, when the remainder is final
			done_q <= busy_q && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) busy_q <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], 1'b0};
			if (!trial[DW]) rem_q <= trial;
			else rem_q <= {rem_q[DW-1:0], quo_q[31]};
		end
	end
	assign done = done_q;
	assign remainder = rem_q[DW-1:0];
endmodule

// ===== design/bucketed_hash_map_top.sv =====
// Bucketed hash map: one transaction at a time. A transaction passes through the
// iterative key modulo (S_DIV), the bucket read sweep over the WAYS ways (S_READ), the
// last RAM read (S_SCAN), write-back (S_WRITE), then S_OUT and S_IDLE; the result is
// registered at write-back. The next input is taken in S_IDLE once the result has been
// taken, so output stalls hold off the next input.
// Reset (arst_n, async) clears control and bucket_count to 256, then a clearing
// pass over all BUCKETS*WAYS slots zeroes the valid RAM before any input is taken.
module bucketed_hash_map_top #(
	parameter int BUCKETS = 256,
	parameter int WAYS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key[31:0], value[63:32]
	input  logic [1:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // value_out
	output logic [1:0]  m_tuser    // status
);
	`include "bucketed_hash_map_top_macros.svh"
	localparam int SLOTS = BUCKETS * WAYS;
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int DW = $clog2(BUCKETS + 1);

	bhm_pkg::state_t state_q, state_d;
	logic [8:0]    bcount_q;
	logic [1:0]    kind_q;
	logic [31:0]   key_q, val_q;
	logic [AW-1:0] base_q, clr_q;
	logic [WW:0]   rway_q, sway_q;
	logic          found_q, free_q;
	logic [WW-1:0] hit_q, freew_q;
	logic [31:0]   hitval_q, rdata_q;
	logic [1:0]    status_q;
	logic          out_v_q;

	logic [DW-1:0] divisor;
	logic          div_done;
	logic [DW-1:0] rem;
	always_comb begin
		if (bcount_q == 9'd0) divisor = DW'(1);
		else if ({23'd0, bcount_q} > BUCKETS) divisor = DW'(BUCKETS);
		else divisor = DW'(bcount_q);
	end

	logic accept;
	assign s_tready = (state_q == bhm_pkg::S_IDLE) && !out_v_q;
	assign accept = s_tvalid && s_tready;

	bhm_divider #(.DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(accept), .dividend(s_tdata[31:0]),
		.divisor(divisor), .done(div_done), .remainder(rem)
	);

	// slot RAMs
	logic [AW-1:0] raddr, waddr;
	logic          we_k, we_v, we_f;
	logic [31:0]   wk, wv;
	logic          wf;
	logic [31:0]   rk, rv;
	logic          rf;
	bhm_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_key (.clk(clk), .we(we_k), .waddr(waddr),
		.wdata(wk), .raddr(raddr), .rdata(rk));
	bhm_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_val (.clk(clk), .we(we_v), .waddr(waddr),
		.wdata(wv), .raddr(raddr), .rdata(rv));
	bhm_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_vld (.clk(clk), .we(we_f), .waddr(waddr),
		.wdata(wf), .raddr(raddr), .rdata(rf));

	assign raddr = base_q + AW'(rway_q[WW-1:0]);
	logic          rd_valid_q;
	logic [WW-1:0] rd_way_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bhm_pkg::S_CLEAR: if (clr_q == AW'(SLOTS - 1)) state_d = bhm_pkg::S_IDLE;
			bhm_pkg::S_IDLE:  if (accept) state_d = bhm_pkg::S_DIV;
			bhm_pkg::S_DIV:   if (div_done) state_d = bhm_pkg::S_READ;
			bhm_pkg::S_READ:  if (rway_q == (WW+1)'(WAYS - 1)) state_d = bhm_pkg::S_SCAN;
			bhm_pkg::S_SCAN:  state_d = bhm_pkg::S_WRITE;
			bhm_pkg::S_WRITE: state_d = bhm_pkg::S_OUT;
			bhm_pkg::S_OUT:   state_d = bhm_pkg::S_IDLE;
			default:          state_d = bhm_pkg::S_IDLE;
		endcase
	end

	// write-back decisions
	always_comb begin
		we_k = 1'b0; we_v = 1'b0; we_f = 1'b0;
		wk = key_q; wv = val_q; wf = 1'b0;
		waddr = base_q;
		case (state_q)
			bhm_pkg::S_CLEAR: begin
				we_f = 1'b1; waddr = clr_q;
			end
			bhm_pkg::S_WRITE: begin
				case (kind_q)
					bhm_pkg::OP_PUT: begin
						if (found_q) begin
							we_v = 1'b1; waddr = base_q + AW'(hit_q);
						end else if (free_q) begin
							we_k = 1'b1; we_v = 1'b1; we_f = 1'b1; wf = 1'b1;
							waddr = base_q + AW'(freew_q);
						end
					end
					bhm_pkg::OP_REMOVE: begin
						if (found_q) begin
							we_f = 1'b1; waddr = base_q + AW'(hit_q);
						end
					end
					bhm_pkg::OP_GET_OR_INSERT: begin
						if (!found_q && free_q) begin
							we_k = 1'b1; we_v = 1'b1; we_f = 1'b1; wf = 1'b1;
							wv = '0; waddr = base_q + AW'(freew_q);
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bhm_pkg::S_CLEAR;
			bcount_q   <= 9'd256;
			clr_q      <= '0;
			rway_q     <= '0;
			rd_valid_q <= 1'b0;
			out_v_q    <= 1'b0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) bcount_q <= cfg_wdata;
			if (state_q == bhm_pkg::S_CLEAR) clr_q <= clr_q + AW'(1);
			rd_valid_q <= (state_q == bhm_pkg::S_READ);
			if (state_q == bhm_pkg::S_DIV) begin
				rway_q <= '0; found_q <= 1'b0; free_q <= 1'b0;
			end else if (state_q == bhm_pkg::S_READ) rway_q <= rway_q + (WW+1)'(1);
			// scan the way returned by the RAM in the cycle after its address
			if (rd_valid_q) begin
				if (rf) begin
					if (!found_q && rk == key_q) found_q <= 1'b1;
				end else if (!free_q) free_q <= 1'b1;
			end
			if (state_q == bhm_pkg::S_WRITE) out_v_q <= 1'b1;
			else if (out_v_q && m_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser; key_q <= s_tdata[31:0]; val_q <= s_tdata[63:32];
		end
		if (div_done) base_q <= AW'(rem) * AW'(WAYS);
		rd_way_q <= rway_q[WW-1:0];
		if (rd_valid_q) begin
			if (rf) begin
				if (!found_q && rk == key_q) begin
					hit_q <= rd_way_q; hitval_q <= rv;
				end
			end else if (!free_q) freew_q <= rd_way_q;
		end
		if (state_q == bhm_pkg::S_WRITE) begin
			rdata_q  <= '0;
			status_q <= bhm_pkg::ST_OK;
			case (kind_q)
				bhm_pkg::OP_GET: begin
					if (found_q) rdata_q <= hitval_q;
					else status_q <= bhm_pkg::ST_NOT_FOUND;
				end
				bhm_pkg::OP_REMOVE: if (!found_q) status_q <= bhm_pkg::ST_NOT_FOUND;
				default: begin
					if (found_q && kind_q == bhm_pkg::OP_GET_OR_INSERT) rdata_q <= hitval_q;
					else if (!found_q && !free_q) status_q <= bhm_pkg::ST_FULL;
				end
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = rdata_q;
	assign m_tuser  = status_q;

	`BHM_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != bhm_pkg::S_IDLE, !s_tready,
		"input accepted while busy")
	`BHM_ASSERT_NXT(a_out_after_write, clk, arst_n, state_q == bhm_pkg::S_WRITE, m_tvalid,
		"no result after write-back")
	`BHM_ASSERT_IMP(a_div_in_div, clk, arst_n, div_done, state_q == bhm_pkg::S_DIV,
		"divider done outside its state")
endmodule

// ===== sim/bucketed_hash_map_top_tb.sv =====
// Self-checking testbench for bucketed_hash_map_top: directed and random map operations,
// predicted by a behavioral slot table. Depends on bhm_pkg and bucketed_hash_map_top.
module bucketed_hash_map_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUCKETS = 256;
	localparam int WAYS = 4;
	localparam int SLOTS = BUCKETS * WAYS;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		bhm_pkg::op_t kind;
		logic [31:0] key;
		logic [31:0] value;
	} map_op_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] value_out;
	} map_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [8:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0] m_tuser;

	bucketed_hash_map_top #(.BUCKETS(BUCKETS), .WAYS(WAYS)) i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] tbl_key [SLOTS];
	logic [31:0] tbl_value [SLOTS];
	bit tbl_valid [SLOTS];
	logic [8:0] nbuckets = 9'd256;

	map_op_t pending_ops[$];
	map_reply_t expected_replies[$];
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_sender = 1'b0;
	longint cycle_count = 0;
	logic [31:0] used_keys[$];

	function automatic map_reply_t apply_map_op(map_op_t op);
		int n;
		int base;
		int hit;
		int free_slot;
		map_reply_t r;
		n = (nbuckets == 0) ? 1 : ((nbuckets > BUCKETS) ? BUCKETS : int'(nbuckets));
		base = int'(op.key % n) * WAYS;
		hit = -1;
		free_slot = -1;
		r = '{status: bhm_pkg::ST_OK, value_out: '0};
		for (int w = 0; w < WAYS; w++) begin
			if (tbl_valid[base + w]) begin
				if (hit < 0 && tbl_key[base + w] == op.key)
					hit = base + w;
			end else if (free_slot < 0) begin
				free_slot = base + w;
			end
		end
		case (op.kind)
			bhm_pkg::OP_PUT: begin
				if (hit >= 0) begin
					tbl_value[hit] = op.value;
				end else if (free_slot >= 0) begin
					tbl_key[free_slot] = op.key;
					tbl_value[free_slot] = op.value;
					tbl_valid[free_slot] = 1'b1;
				end else begin
					r.status = bhm_pkg::ST_FULL;
				end
			end
			bhm_pkg::OP_GET: begin
				if (hit >= 0) r.value_out = tbl_value[hit];
				else r.status = bhm_pkg::ST_NOT_FOUND;
			end
			bhm_pkg::OP_REMOVE: begin
				if (hit >= 0) tbl_valid[hit] = 1'b0;
				else r.status = bhm_pkg::ST_NOT_FOUND;
			end
			default: begin
				if (hit >= 0) begin
					r.value_out = tbl_value[hit];
				end else if (free_slot >= 0) begin
					tbl_key[free_slot] = op.key;
					tbl_value[free_slot] = '0;
					tbl_valid[free_slot] = 1'b1;
				end else begin
					r.status = bhm_pkg::ST_FULL;
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// driver
	always @(posedge clk) begin
		map_op_t op;
		if (s_tvalid && s_tready) begin
			op = pending_ops.pop_front();
			expected_replies.push_back(apply_map_op(op));
		end
		if ((!s_tvalid || s_tready) && arst_n) begin
			if (pending_ops.size() > 0 && !hold_sender
					&& $urandom_range(99) >= send_idle_pct) begin
				op = pending_ops[0];
				s_tvalid <= 1'b1;
				s_tdata <= {op.value, op.key};
				s_tuser <= op.kind;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		map_reply_t want;
		cycle_count++;
		if (m_tvalid && m_tready) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("unexpected reply", {30'd0, m_tuser}, '0);
			end else begin
				want = expected_replies.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", {30'd0, m_tuser}, {30'd0, want.status});
				if (m_tdata !== want.value_out)
					report_mismatch("value_out", m_tdata, want.value_out);
			end
		end
		m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [31:0] pick_key();
		int c;
		c = $urandom_range(9);
		if (c < 7 && used_keys.size() > 0) return used_keys[$urandom_range(used_keys.size() - 1)];
		if (c == 7) return {2'($urandom_range(3)), 24'd0, 6'($urandom_range(63))};
		return $urandom;
	endfunction

	task automatic queue_op(input bhm_pkg::op_t kind, input logic [31:0] key,
			input logic [31:0] value);
		pending_ops.push_back('{kind: kind, key: key, value: value});
	endtask

	task automatic drain();
		wait (pending_ops.size() == 0 && !s_tvalid);
		wait (expected_replies.size() == 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_bucket_count(input logic [8:0] n);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we <= 1'b0;
		nbuckets = n;
	endtask

	task automatic random_phase(input int count, input int idle, input int stall);
		logic [31:0] k;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			k = pick_key();
			if (used_keys.size() < 48) used_keys.push_back(k);
			queue_op(bhm_pkg::op_t'($urandom_range(3)), k, $urandom);
		end
		drain();
	endtask

	initial begin
		// slots read only when valid; zero fill just keeps the table defined
		for (int i = 0; i < SLOTS; i++) begin
			tbl_key[i] = '0;
			tbl_value[i] = '0;
			tbl_valid[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, all ops, full bucket, missing key, lowest free way
		queue_op(bhm_pkg::OP_GET, 32'h0, 32'h0);
		queue_op(bhm_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
		queue_op(bhm_pkg::OP_PUT, 32'h0, 32'hFFFF_FFFF);
		queue_op(bhm_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0);
		queue_op(bhm_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
		queue_op(bhm_pkg::OP_GET_OR_INSERT, 32'h0, 32'h1234);
		for (int i = 1; i <= 4; i++) queue_op(bhm_pkg::OP_PUT, 32'(i * 256), 32'(i));
		queue_op(bhm_pkg::OP_GET_OR_INSERT, 32'd1280, 32'h0);
		queue_op(bhm_pkg::OP_PUT, 32'd0, 32'hA5A5_5A5A);
		queue_op(bhm_pkg::OP_REMOVE, 32'd512, 32'h0);
		queue_op(bhm_pkg::OP_GET_OR_INSERT, 32'd1536, 32'h0);
		queue_op(bhm_pkg::OP_GET_OR_INSERT, 32'd1536, 32'h0);
		queue_op(bhm_pkg::OP_GET, 32'd512, 32'h0);
		queue_op(bhm_pkg::OP_GET, 32'd0, 32'h0);
		queue_op(bhm_pkg::OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
		queue_op(bhm_pkg::OP_GET, 32'hAAAA_AAAA, 32'h0);
		drain();

		write_bucket_count(9'd0);
		queue_op(bhm_pkg::OP_GET, 32'd7, 32'h0);
		queue_op(bhm_pkg::OP_PUT, 32'd7, 32'd70);
		queue_op(bhm_pkg::OP_GET, 32'd7, 32'd0);
		drain();

		write_bucket_count(9'd511);
		random_phase(300, 0, 0);

		// stale entries stay; the predictor sees the same
		write_bucket_count(9'd1);
		random_phase(250, 86, 0);
		write_bucket_count(9'd3);
		random_phase(300, 0, 86);
		write_bucket_count(9'd256);
		random_phase(300, 13, 13);

		// sender held back while a reply is outstanding, until all replies are in
		queue_op(bhm_pkg::OP_GET_OR_INSERT, 32'hFFFF_FFFF, 32'h0);
		wait (expected_replies.size() != 0);
		hold_sender = 1'b1;
		queue_op(bhm_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
		queue_op(bhm_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0BAD_F00D);
		wait (expected_replies.size() == 0);
		repeat (20) @(posedge clk);
		hold_sender = 1'b0;
		drain();
		write_bucket_count(9'd17);
		random_phase(350, 0, 0);
		write_bucket_count(9'd255);
		random_phase(330, 13, 13);

		if (error_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ===== bucketed_hash_map_top.f =====
+incdir+design
design/bhm_pkg.sv
design/bhm_ram.sv
design/bhm_divider.sv
design/bucketed_hash_map_top.sv
sim/bucketed_hash_map_top_tb.sv
